// File: hdl/sltc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltc_pkg: shared types and constants for the soft-limit teach/check core
// Request and response payload structs, widths and register indexes.
// ----------------------------------------------------------------------------
package sltc_pkg;

   localparam int POS_WIDTH  = 32;
   localparam int TIME_WIDTH = 32;

   // wide enough for pos +/- a 20-bit margin without overflow
   localparam int EXT_WIDTH = ((POS_WIDTH > 20) ? POS_WIDTH : 21) + 1;
   // duration compare width: time span vs 16-bit threshold
   localparam int DUR_WIDTH = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

   localparam int CSR_IDX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int NUM_LIMITS = 4;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LONG_PRESS_MS = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LIMIT_MARGIN  = CSR_IDX_WIDTH'(1);
   localparam logic [CSR_IDX_WIDTH-1:0] REG_TEST_MODE     = CSR_IDX_WIDTH'(2);
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LIMITS_ENABLE = CSR_IDX_WIDTH'(3);

   // register reset values
   localparam logic [15:0] LONG_PRESS_MS_RST = 16'd600;
   localparam logic [19:0] LIMIT_MARGIN_RST  = 20'd150;
   localparam logic        TEST_MODE_RST     = 1'b0;
   localparam logic        LIMITS_ENABLE_RST = 1'b1;

   // limit slots
   localparam int LIM_X_NEG = 0;
   localparam int LIM_X_POS = 1;
   localparam int LIM_Z_NEG = 2;
   localparam int LIM_Z_POS = 3;

   typedef struct packed {
      logic                         btn_x_neg;
      logic                         btn_x_pos;
      logic                         btn_z_neg;
      logic                         btn_z_pos;
      logic [TIME_WIDTH-1:0]        now_ms;
      logic signed [POS_WIDTH-1:0]  x_pos;
      logic signed [POS_WIDTH-1:0]  z_pos;
      logic                         clear_all;
   } req_type;

   typedef struct packed {
      logic led_x_neg;
      logic led_x_pos;
      logic led_z_neg;
      logic led_z_pos;
      logic x_limits_active;
      logic z_limits_active;
      logic x_in_range;
      logic z_in_range;
   } rsp_type;

endpackage

// File: hdl/soft_limit_teach_and_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_limit_teach_and_check_core: teach and check soft axis limits
// Button press tracking, limit teaching on release and widened range check.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle when the response side keeps up; each
// request gives exactly one response, held first in the input register and
// then in the response register, and the request stall only rises when the
// response register is full and stalled. Each request carries four limit
// buttons, a millisecond timestamp, X/Z positions and a clear flag. A release
// after a press shorter than long_press_ms teaches that limit at the current
// axis position; an equal or longer press clears it. clear_all wipes all
// limits after the release handling of the same request. The response flags
// reflect the limit state after that request. Registers are written through
// the csr port (always ready) and should only be written while idle.
// ----------------------------------------------------------------------------
module soft_limit_teach_and_check_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sltc_pkg::req_type                    req_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sltc_pkg::rsp_type                    rsp_data,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sltc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [sltc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import sltc_pkg::*;

   // config registers
   logic [15:0] long_press_ms_ff;
   logic [19:0] limit_margin_ff;
   logic        test_mode_ff;
   logic        limits_enable_ff;

   // pipeline
   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    advance;

   // limit state
   logic signed [POS_WIDTH-1:0] limit_value_ff [NUM_LIMITS];
   logic signed [POS_WIDTH-1:0] limit_value_in [NUM_LIMITS];
   logic [NUM_LIMITS-1:0]       taught_ff, taught_in;
   logic [NUM_LIMITS-1:0]       prev_btn_ff;
   logic [TIME_WIDTH-1:0]       press_start_ff [NUM_LIMITS];
   logic [TIME_WIDTH-1:0]       press_start_in [NUM_LIMITS];

   logic [NUM_LIMITS-1:0]       btn;
   logic [TIME_WIDTH-1:0]       dur [NUM_LIMITS];
   rsp_type                     rsp_in;
   logic                        x_ok, z_ok;

   // ------------------------------------------------------------------
   // Handshake: response register drains first, then stage 1 moves on.
   // ------------------------------------------------------------------
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign btn = {s1_req_ff.btn_z_pos, s1_req_ff.btn_z_neg,
                 s1_req_ff.btn_x_pos, s1_req_ff.btn_x_neg};

   // ------------------------------------------------------------------
   // Per-limit press tracking and teaching. Start of zero = no press.
   // ------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < NUM_LIMITS; i++) begin
         limit_value_in[i] = limit_value_ff[i];
         taught_in[i]      = taught_ff[i];
         press_start_in[i] = press_start_ff[i];
         dur[i]            = s1_req_ff.now_ms - press_start_ff[i];
         if (btn[i]) begin
            if (press_start_ff[i] == '0) begin
               press_start_in[i] = s1_req_ff.now_ms;
            end
         end else begin
            if (prev_btn_ff[i] && (press_start_ff[i] != '0)) begin
               if (DUR_WIDTH'(dur[i]) >= DUR_WIDTH'(long_press_ms_ff)) begin
                  taught_in[i] = 1'b0;
               end else begin
                  limit_value_in[i] = (i < 2) ? s1_req_ff.x_pos : s1_req_ff.z_pos;
                  taught_in[i]      = 1'b1;
               end
            end
            press_start_in[i] = '0;
         end
         // clear wins over a same-request teach
         if (s1_req_ff.clear_all) begin
            limit_value_in[i] = '0;
            taught_in[i]      = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Range check on the updated limits: sorted, widened by the margin.
   // ------------------------------------------------------------------
   function automatic logic axis_ok(input logic signed [POS_WIDTH-1:0] va,
                                    input logic signed [POS_WIDTH-1:0] vb,
                                    input logic signed [POS_WIDTH-1:0] pos,
                                    input logic [19:0]                 margin);
      logic signed [EXT_WIDTH-1:0] lo, hi, p, m;
      lo = EXT_WIDTH'((va < vb) ? va : vb);
      hi = EXT_WIDTH'((va < vb) ? vb : va);
      p  = EXT_WIDTH'(pos);
      m  = $signed(EXT_WIDTH'(margin));
      return (p >= lo - m) && (p <= hi + m);
   endfunction

   always_comb begin
      x_ok = axis_ok(limit_value_in[LIM_X_NEG], limit_value_in[LIM_X_POS],
                     s1_req_ff.x_pos, limit_margin_ff);
      z_ok = axis_ok(limit_value_in[LIM_Z_NEG], limit_value_in[LIM_Z_POS],
                     s1_req_ff.z_pos, limit_margin_ff);

      rsp_in.led_x_neg = test_mode_ff ? btn[LIM_X_NEG] : taught_in[LIM_X_NEG];
      rsp_in.led_x_pos = test_mode_ff ? btn[LIM_X_POS] : taught_in[LIM_X_POS];
      rsp_in.led_z_neg = test_mode_ff ? btn[LIM_Z_NEG] : taught_in[LIM_Z_NEG];
      rsp_in.led_z_pos = test_mode_ff ? btn[LIM_Z_POS] : taught_in[LIM_Z_POS];
      rsp_in.x_limits_active = limits_enable_ff && taught_in[LIM_X_NEG]
                               && taught_in[LIM_X_POS];
      rsp_in.z_limits_active = limits_enable_ff && taught_in[LIM_Z_NEG]
                               && taught_in[LIM_Z_POS];
      // incomplete limits always pass
      rsp_in.x_in_range = !(taught_in[LIM_X_NEG] && taught_in[LIM_X_POS]) || x_ok;
      rsp_in.z_in_range = !(taught_in[LIM_Z_NEG] && taught_in[LIM_Z_POS]) || z_ok;
   end

   // ------------------------------------------------------------------
   // Payload registers (no reset)
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // ------------------------------------------------------------------
   // Control, limit state and config registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         long_press_ms_ff <= LONG_PRESS_MS_RST;
         limit_margin_ff  <= LIMIT_MARGIN_RST;
         test_mode_ff     <= TEST_MODE_RST;
         limits_enable_ff <= LIMITS_ENABLE_RST;
         taught_ff        <= '0;
         prev_btn_ff      <= '0;
         for (int i = 0; i < NUM_LIMITS; i++) begin
            limit_value_ff[i] <= '0;
            press_start_ff[i] <= '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            taught_ff   <= taught_in;
            prev_btn_ff <= btn;
            for (int i = 0; i < NUM_LIMITS; i++) begin
               limit_value_ff[i] <= limit_value_in[i];
               press_start_ff[i] <= press_start_in[i];
            end
         end

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_LONG_PRESS_MS: long_press_ms_ff <= csr_wdata[15:0];
               REG_LIMIT_MARGIN:  limit_margin_ff  <= csr_wdata[19:0];
               REG_TEST_MODE:     test_mode_ff     <= csr_wdata[0];
               REG_LIMITS_ENABLE: limits_enable_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: hdl/sltc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltc_checker: port-level checks for the soft-limit teach/check core
// Latency, back-pressure and response hold checks, bound to the top level.
// ----------------------------------------------------------------------------
module sltc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sltc_pkg::rsp_type rsp_data
);
   import sltc_pkg::*;

   // comes out of reset with no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // request side only stalls behind a full, stalled response register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without response back-pressure");

   // a request taken while no response is valid leads to a valid response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
      else $error("response missing after accepted request");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed or dropped");

endmodule

bind soft_limit_teach_and_check_core sltc_checker u_sltc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: verif/soft_limit_teach_and_check_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_limit_teach_and_check_core_test: self-checking bench for the limit core
// Walks a short table of directed samples, then runs press/release sequences
// with random timing and positions under several register settings. Every
// response is compared field by field with a typed row or the limit predictor.
// ----------------------------------------------------------------------------
module soft_limit_teach_and_check_core_test;
   import sltc_pkg::*;

   localparam int LIMIT_CYCLES = 100000;
   localparam int N_PHASES     = 7;
   localparam int PHASE_ITEMS  = 100;
   localparam int REQ_BITS     = $bits(req_type);

   // one row of the directed table; want is only used when typed is set
   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // typed expectation travels with the request so the monitor sees it at
   // the same edge as the request itself
   bit      req_typed = 1'b0;
   rsp_type req_want  = '0;

   // predictor copy of the registers
   logic [15:0] lp_cfg     = LONG_PRESS_MS_RST;
   logic [19:0] margin_cfg = LIMIT_MARGIN_RST;
   logic        test_cfg   = TEST_MODE_RST;
   logic        enable_cfg = LIMITS_ENABLE_RST;

   // predictor copy of the limit state, indexed by LIM_*
   longint      lim_val    [NUM_LIMITS] = '{default: 0};
   bit          lim_taught [NUM_LIMITS] = '{default: 1'b0};
   bit          btn_was    [NUM_LIMITS] = '{default: 1'b0};
   logic [31:0] press_at   [NUM_LIMITS] = '{default: '0};

   rsp_type flags_due [$];
   int      n_mismatch    = 0;
   int      cycles        = 0;
   int      send_idle_pct = 6;
   int      rcv_idle_pct  = 51;

   // field names, MSB first, matching the packed order of rsp_type
   string flag_name [8] = '{"led_x_neg", "led_x_pos", "led_z_neg", "led_z_pos",
                            "x_limits_active", "z_limits_active",
                            "x_in_range", "z_in_range"};

   soft_limit_teach_and_check_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop in case the handshakes hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("soft_limit_teach_and_check_core_test: errors");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   // Range check with the sorted limits widened by the margin. Incomplete axes
   // always pass; math is 64-bit so extreme positions plus margin cannot wrap.
   function automatic bit within_soft_limits(int a, int b, longint pos);
      longint lo, hi, m;
      if (!lim_taught[a] || !lim_taught[b])
         return 1'b1;
      lo = (lim_val[a] < lim_val[b]) ? lim_val[a] : lim_val[b];
      hi = (lim_val[a] > lim_val[b]) ? lim_val[a] : lim_val[b];
      m  = longint'(margin_cfg);
      return (pos >= lo - m) && (pos <= hi + m);
   endfunction

   // Advance the limit state by one sample and return the flags it yields.
   function automatic rsp_type next_limit_flags(req_type r);
      logic        btn [NUM_LIMITS];
      logic [31:0] held_for;
      longint      xp, zp;
      rsp_type     f;
      btn[LIM_X_NEG] = r.btn_x_neg;
      btn[LIM_X_POS] = r.btn_x_pos;
      btn[LIM_Z_NEG] = r.btn_z_neg;
      btn[LIM_Z_POS] = r.btn_z_pos;
      xp = $signed(r.x_pos);
      zp = $signed(r.z_pos);
      for (int i = 0; i < NUM_LIMITS; i++) begin
         if (btn[i]) begin
            // a start of zero means no press, so a press at t=0 is re-latched
            if (press_at[i] == 0)
               press_at[i] = r.now_ms;
         end else begin
            // release without a recorded start is ignored
            if (btn_was[i] && press_at[i] != 0) begin
               held_for = r.now_ms - press_at[i];   // wraps mod 2^32
               if (held_for >= lp_cfg) begin
                  lim_taught[i] = 1'b0;
               end else begin
                  lim_val[i]    = (i == LIM_X_NEG || i == LIM_X_POS) ? xp : zp;
                  lim_taught[i] = 1'b1;
               end
            end
            press_at[i] = '0;
         end
         btn_was[i] = btn[i];
      end
      // clear lands after release handling; button tracking untouched
      if (r.clear_all) begin
         for (int i = 0; i < NUM_LIMITS; i++) begin
            lim_val[i]    = 0;
            lim_taught[i] = 1'b0;
         end
      end
      f.led_x_neg = test_cfg ? btn[LIM_X_NEG] : lim_taught[LIM_X_NEG];
      f.led_x_pos = test_cfg ? btn[LIM_X_POS] : lim_taught[LIM_X_POS];
      f.led_z_neg = test_cfg ? btn[LIM_Z_NEG] : lim_taught[LIM_Z_NEG];
      f.led_z_pos = test_cfg ? btn[LIM_Z_POS] : lim_taught[LIM_Z_POS];
      f.x_limits_active = enable_cfg && lim_taught[LIM_X_NEG] && lim_taught[LIM_X_POS];
      f.z_limits_active = enable_cfg && lim_taught[LIM_Z_NEG] && lim_taught[LIM_Z_POS];
      f.x_in_range = within_soft_limits(LIM_X_NEG, LIM_X_POS, xp);
      f.z_in_range = within_soft_limits(LIM_Z_NEG, LIM_Z_POS, zp);
      return f;
   endfunction

   // Monitor: both handshakes are sampled at the edge with pre-edge values.
   // The request side is handled first so the queue is current before a
   // response is popped.
   always @(posedge clock) begin
      rsp_type pred;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pred = next_limit_flags(req_data);
            flags_due.push_back(req_typed ? req_want : pred);
         end
         if (rsp_valid && !rsp_stall) begin
            if (flags_due.size() == 0) begin
               $error("response with no request outstanding: %b", rsp_data);
               n_mismatch++;
            end else begin
               pred = flags_due.pop_front();
               for (int i = 0; i < 8; i++) begin
                  if (pred[7-i] !== rsp_data[7-i]) begin
                     $error("%s: expected %0b, got %0b", flag_name[i], pred[7-i],
                            rsp_data[7-i]);
                     n_mismatch++;
                  end
               end
            end
         end
      end
   end

   function automatic plan_row_type mk(logic [3:0] b, logic [31:0] t, logic [31:0] x,
                                       logic [31:0] z, bit clr, bit typed,
                                       logic [7:0] want);
      plan_row_type row;
      {row.r.btn_x_neg, row.r.btn_x_pos, row.r.btn_z_neg, row.r.btn_z_pos} = b;
      row.r.now_ms    = t;
      row.r.x_pos     = x;
      row.r.z_pos     = z;
      row.r.clear_all = clr;
      row.typed       = typed;
      row.want        = rsp_type'(want);
      return row;
   endfunction

   // Position near a limit edge (margin +/- 1), in a small window, or anywhere.
   function automatic logic [31:0] probe_pos(int a);
      longint off;
      off = longint'(margin_cfg) + longint'($urandom_range(0, 2)) - 1;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'(int'($urandom_range(0, 40000)) - 20000);
         2: return 32'(lim_val[a + $urandom_range(0, 1)] - off);
         default: return 32'(lim_val[a + $urandom_range(0, 1)] + off);
      endcase
   endfunction

   // Drive one request; valid stays up into the next call if no gap is drawn.
   task automatic send_req(input req_type r, input bit typed, input rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      req_typed <= typed;
      req_want  <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off until every outstanding response is back, plus pipeline slack.
   // The first edge lets the monitor log the last accepted request.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (flags_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers back to back; junk in unused data bits.
   task automatic set_config(input logic [15:0] lp, input logic [19:0] mg,
                             input logic tm, input logic en);
      logic [CSR_IDX_WIDTH-1:0]  idx [4];
      logic [CSR_DATA_WIDTH-1:0] val [4];
      idx = '{REG_LONG_PRESS_MS, REG_LIMIT_MARGIN, REG_TEST_MODE, REG_LIMITS_ENABLE};
      val = '{{16'($urandom()), lp}, {12'($urandom()), mg},
              {31'($urandom()), tm}, {31'($urandom()), en}};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[k])
            REG_LONG_PRESS_MS: lp_cfg     = val[k][15:0];
            REG_LIMIT_MARGIN:  margin_cfg = val[k][19:0];
            REG_TEST_MODE:     test_cfg   = val[k][0];
            REG_LIMITS_ENABLE: enable_cfg = val[k][0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      plan_row_type               plan [$];
      req_type                    r;
      logic [REQ_BITS-1:0]        raw;
      logic [3:0]                 held;
      logic [31:0]                t_now, step;
      logic [15:0]                lp_set [N_PHASES];
      logic [19:0]                mg_set [N_PHASES];
      logic                       tm_set [N_PHASES];
      logic                       en_set [N_PHASES];
      int                         n;

      // register settings per phase; reset values first, then extremes, the last one is drawn
      lp_set = '{16'd600, 16'd1, 16'hFFFF, 16'd40, 16'd300, 16'd1000, 16'd0};
      mg_set = '{20'd150, 20'd0, 20'hFFFFF, 20'd1000000, 20'd0, 20'd5, 20'd0};
      tm_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      en_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table, reset register values (threshold 600, margin 150).
      // Buttons are {x_neg, x_pos, z_neg, z_pos}; typed flags are
      // {leds x_neg..z_pos, x_active, z_active, x_in, z_in}.
      plan = '{
         // idle after reset, extreme positions, nothing taught
         mk(4'b0000, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 8'b0000_0011),
         // press at time zero: start not latched until the next sample
         mk(4'b1000, 32'd0,   32'd0,         32'd0,         1'b0, 1'b1, 8'b0000_0011),
         mk(4'b1000, 32'd10,  32'd0,         32'd0,         1'b0, 1'b1, 8'b0000_0011),
         // short release teaches x_neg at -1.000 mm
         mk(4'b0000, 32'd20,  -32'sd1000,    32'd0,         1'b0, 1'b1, 8'b1000_0011),
         mk(4'b0100, 32'd30,  32'd0,         32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd40,  32'd5000,      32'd0,         1'b0, 1'b0, 8'h00),
         // window edges: [-1000 - 150, 5000 + 150]
         mk(4'b0000, 32'd50,  32'd5150,      32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd51,  32'd5151,      32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd52,  -32'sd1150,    32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd53,  -32'sd1151,    32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd60,  32'h8000_0000, 32'd0,         1'b0, 1'b1, 8'b1100_1001),
         // both Z buttons together, taught at the same spot
         mk(4'b0011, 32'd2000, 32'd0,        32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd2005, 32'd0,        -32'sd7,       1'b0, 1'b0, 8'h00),
         // one ms under the threshold still teaches
         mk(4'b0001, 32'd3000, 32'd0,        32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd3599, 32'd0,        32'd9000,      1'b0, 1'b0, 8'h00),
         // exactly at the threshold untaughts z_neg
         mk(4'b0010, 32'd4000, 32'd0,        32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd4600, 32'd0,        32'd0,         1'b0, 1'b1, 8'b1101_1011),
         // press across the 32-bit time wrap
         mk(4'b1000, 32'hFFFF_FFF0, 32'd0,   32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd5,   -32'sd300,     32'd0,         1'b0, 1'b0, 8'h00),
         // pressed at t=0 and released at once: no start, nothing happens
         mk(4'b0100, 32'd0,   32'd0,         32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd1,   32'd77,        32'd0,         1'b0, 1'b0, 8'h00),
         // release and clear on the same sample: clear wins
         mk(4'b0001, 32'd7000, 32'd0,        32'd0,         1'b0, 1'b0, 8'h00),
         mk(4'b0000, 32'd7010, 32'd0,        32'd123,       1'b1, 1'b1, 8'b0000_0011),
         // all buttons at max time, then taught together at the extremes
         mk(4'b1111, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1,
            8'b0000_0011),
         mk(4'b0000, 32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
            8'b1111_1111)
      };
      foreach (plan[i])
         send_req(plan[i].r, plan[i].typed, plan[i].want);

      // Random part: mostly press/release sequences with durations drawn around
      // the threshold and positions probed around the taught edges; about one
      // sample in ten is raw noise.
      held  = '0;
      t_now = 32'd5000;
      n     = 0;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain();
         if (ph == N_PHASES - 1)
            set_config(16'($urandom_range(1, 65535)), 20'($urandom()),
                       1'($urandom()), 1'($urandom()));
         else
            set_config(lp_set[ph], mg_set[ph], tm_set[ph], en_set[ph]);

         for (int j = 0; j < PHASE_ITEMS; j++) begin
            // idle mix: sender light / receiver heavy, then swapped, then none
            if (n == N_PHASES * PHASE_ITEMS / 3) begin
               send_idle_pct = 51;
               rcv_idle_pct  = 6;
            end
            if (n == 2 * N_PHASES * PHASE_ITEMS / 3) begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
            // let the pipe run dry once mid-stream
            if (ph == 1 && j == PHASE_ITEMS / 2)
               drain();

            case ($urandom_range(0, 9))
               0:          step = '0;
               1, 2, 3, 4: step = $urandom_range(1, lp_cfg / 3 + 1);
               5, 6:       step = lp_cfg - 1 + $urandom_range(0, 2);
               7, 8:       step = $urandom_range(1, 2 * int'(lp_cfg));
               default:    step = $urandom();
            endcase
            t_now = t_now + step;
            if ($urandom_range(0, 49) == 0)
               t_now = '0;
            for (int b = 0; b < 4; b++)
               if ($urandom_range(0, 3) == 0)
                  held[b] = ~held[b];

            {r.btn_x_neg, r.btn_x_pos, r.btn_z_neg, r.btn_z_pos} = held;
            r.now_ms    = t_now;
            r.x_pos     = probe_pos(LIM_X_NEG);
            r.z_pos     = probe_pos(LIM_Z_NEG);
            r.clear_all = ($urandom_range(0, 49) == 0);
            if ($urandom_range(0, 9) == 0) begin
               raw         = REQ_BITS'({$urandom(), $urandom(), $urandom(), $urandom()});
               r           = raw;
               r.clear_all = ($urandom_range(0, 7) == 0);
            end
            send_req(r, 1'b0, '0);
            n++;
         end
      end

      drain();
      if (n_mismatch == 0)
         $display("soft_limit_teach_and_check_core_test: clean");
      else
         $display("soft_limit_teach_and_check_core_test: errors");
      $finish;
   end

endmodule
